[hw/rtl/bat_pkg.sv]
package bat_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int ADDR_W = 16;
   localparam int OP_W = 3;
   localparam int COUNT_OUT_W = 5;

   localparam logic [ADDR_W-1:0] NO_ADDR = 16'hFFFF;

   localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
   localparam logic [OP_W-1:0] OP_SET_TEMP = 3'd2;
   localparam logic [OP_W-1:0] OP_CHECK    = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

   typedef struct packed {
      logic remove;
      logic append;
      logic clear;
   } cmd_type;

endpackage

[hw/rtl/bat_cell.sv]
module bat_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  bat_pkg::cmd_type             cmd,
   input  logic [bat_pkg::ADDR_W-1:0]   key,
   input  logic                         seen_in,
   output logic                         seen_out,
   input  logic                         prev_valid,
   input  logic                         next_valid,
   input  logic [bat_pkg::ADDR_W-1:0]   next_entry,
   output logic                         valid_out,
   output logic [bat_pkg::ADDR_W-1:0]   entry_out
);

   logic                       valid_ff;
   logic                       valid_in;
   logic [bat_pkg::ADDR_W-1:0] entry_ff;
   logic [bat_pkg::ADDR_W-1:0] entry_in;
   logic                       match;
   logic                       shift;
   logic                       take;

   assign match    = valid_ff && (entry_ff == key);
   assign seen_out = seen_in | match;
   // at or above the hole: pull the upper neighbor down
   assign shift    = cmd.remove && seen_out;
   // first free slot takes the appended address
   assign take     = cmd.append && !valid_ff && prev_valid;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (shift) begin
         valid_in = next_valid;
         entry_in = next_entry;
      end else if (take) begin
         valid_in = 1'b1;
         entry_in = key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign valid_out = valid_ff;
   assign entry_out = entry_ff;

endmodule

[hw/rtl/breakpoint_address_table_top.sv]
// Latency: result is registered and appears in the cycle after the item is accepted; set
// temporary first removes the old temporary, then looks up and appends in the ST_TEMP pass.
// Throughput: one item per cycle while results are taken and no set temporary is pending.
// Rate is set by the single result register and the two-pass set-temporary sequence.
// Reset: synchronous; clears every cell's valid bit, the count and the temporary
// address. Entry payloads are not cleared.
module breakpoint_address_table_top #(
   parameter int DEPTH = bat_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] address
   input  logic [2:0]  req_tuser,   // [2:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] accepted, [1] hit, [6:2] entry_count, [7] zero
);

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic {ST_IDLE, ST_TEMP} state_type;

   state_type                  state_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_accepted_ff;
   logic                       rsp_hit_ff;
   logic [bat_pkg::COUNT_OUT_W-1:0] rsp_count_ff;
   logic [CW-1:0]              count_ff;
   logic [CW-1:0]              count_in;
   logic [bat_pkg::ADDR_W-1:0] temp_ff;
   logic [bat_pkg::ADDR_W-1:0] hold_ff;

   logic [bat_pkg::OP_W-1:0]   op;
   logic [bat_pkg::ADDR_W-1:0] addr;
   logic [bat_pkg::ADDR_W-1:0] key;
   logic                       accept;
   logic                       full;
   logic                       hit_any;
   bat_pkg::cmd_type           cmd;

   logic [DEPTH:0]             seen;
   logic [DEPTH:0]             valid_w;
   logic [bat_pkg::ADDR_W-1:0] entry_w [DEPTH+1];

   assign op   = req_tuser;
   assign addr = req_tdata;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign key = (state_ff == ST_TEMP)  ? hold_ff :
                (op == bat_pkg::OP_SET_TEMP) ? temp_ff : addr;

   assign full    = (count_ff == CW'(DEPTH));
   assign hit_any = seen[DEPTH];

   always_comb begin
      cmd = '0;
      if (state_ff == ST_TEMP) begin
         cmd.append = (hold_ff != bat_pkg::NO_ADDR) && !hit_any && !full;
      end else if (accept) begin
         unique case (op)
            bat_pkg::OP_ADD: begin
               cmd.append = (addr != bat_pkg::NO_ADDR) && !hit_any && !full;
            end
            bat_pkg::OP_REMOVE: begin
               cmd.remove = 1'b1;
            end
            bat_pkg::OP_SET_TEMP: begin
               cmd.remove = (temp_ff != bat_pkg::NO_ADDR);
            end
            bat_pkg::OP_CLEAR: begin
               cmd.clear = 1'b1;
            end
            default: begin
               cmd = '0;
            end
         endcase
      end
   end

   always_comb begin
      priority if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.remove && hit_any) begin
         count_in = count_ff - CW'(1);
      end else if (cmd.append) begin
         count_in = count_ff + CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   assign seen[0]           = 1'b0;
   assign valid_w[DEPTH]    = 1'b0;
   assign entry_w[DEPTH]    = bat_pkg::NO_ADDR;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic prev_valid;
      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_rest
         assign prev_valid = valid_w[i-1];
      end
      bat_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .key        (key),
         .seen_in    (seen[i]),
         .seen_out   (seen[i+1]),
         .prev_valid (prev_valid),
         .next_valid (valid_w[i+1]),
         .next_entry (entry_w[i+1]),
         .valid_out  (valid_w[i]),
         .entry_out  (entry_w[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         temp_ff      <= bat_pkg::NO_ADDR;
      end else begin
         count_ff <= count_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (op == bat_pkg::OP_SET_TEMP)) begin
                  temp_ff  <= bat_pkg::NO_ADDR;
                  hold_ff  <= addr;
                  state_ff <= ST_TEMP;
               end
               if (accept && (op != bat_pkg::OP_SET_TEMP)) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_accepted_ff <= cmd.append ||
                                     ((op == bat_pkg::OP_REMOVE) && hit_any);
                  rsp_hit_ff      <= (op == bat_pkg::OP_CHECK) && hit_any;
                  rsp_count_ff    <= bat_pkg::COUNT_OUT_W'(count_in);
               end else if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_TEMP: begin
               rsp_valid_ff    <= 1'b1;
               rsp_accepted_ff <= cmd.append;
               rsp_hit_ff      <= 1'b0;
               rsp_count_ff    <= bat_pkg::COUNT_OUT_W'(count_in);
               if (cmd.append) begin
                  temp_ff <= hold_ff;
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_hit_ff, rsp_accepted_ff};

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      count_ff == CW'($countones(valid_w[DEPTH-1:0])))
      else $error("entry count differs from number of valid cells");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_temp_no_pending_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEMP) |-> !rsp_valid_ff)
      else $error("result pending during set-temporary second pass");

   a_temp_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEMP) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("set-temporary did not produce a result");

endmodule
